@@ hdl/record_sort_by_key_unit_macros.svh @@
// assertion macros shared by the checker
`ifndef RECORD_SORT_BY_KEY_UNIT_MACROS_SVH
`define RECORD_SORT_BY_KEY_UNIT_MACROS_SVH

`define RSK_ASSERT_IMPL(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

`define RSK_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

@@ hdl/rsk_pkg.sv @@
`default_nettype none
package rsk_pkg;
  localparam int unsigned KEY_W = 27;
  localparam int unsigned TAG_W = 32;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [TAG_W-1:0] tag_t;

  typedef struct packed {
    key_t key;
    tag_t tag;
  } rec_t;

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_SHIFT = 4'b0010,
    ST_EMIT  = 4'b0100,
    ST_WAIT  = 4'b1000
  } state_t;
endpackage
`default_nettype wire

@@ hdl/record_sort_by_key_unit.sv @@
// channel  | dir | tdata fields (low bit up)           | tuser
// in_      | in  | record_key[26:0], record_tag[58:27] | -, tlast = is_last
// out_     | out | sorted_key[26:0], sorted_tag[58:27] | dropped, tlast = last_out
// a record is inserted by walking down from the top of the sorted store, one
// read-compare-move per cycle on the single memory; the first record of a list
// is written straight to entry 0 and a dropped one is not stored, so neither walks;
// emission reads one entry per cycle, one beat per cycle without stall
// synchronous active-low reset clears count, overflow flag and control; store is
// left undefined; output stalls hold the beat in the output register
`default_nettype none
module record_sort_by_key_unit import rsk_pkg::*; #(
  parameter int unsigned ENTRIES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // record_key, record_tag, zero fill
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // sorted_key, sorted_tag, zero fill
  output logic             out_tlast,
  output logic             out_tuser   // dropped
);
  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);

  rec_t mem [ENTRIES];
  rec_t rd_q;

  state_t   state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, pos_r, pos_nxt;
  logic     ovf_r, ovf_nxt, last_r, last_nxt;
  rec_t     new_r, new_nxt;
  logic     rd_en, wr_en;
  logic [AW-1:0] rd_a, wr_a;
  rec_t     wr_d;
  logic     emit_pend_r, emit_pend_nxt;
  logic [CW-1:0] epos_r, epos_nxt;
  logic     ov_r, ov_nxt;
  rec_t     ob_r, ob_nxt;
  logic     ol_r, ol_nxt, od_r, od_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_a] <= wr_d;
    if (rd_en) rd_q <= mem[rd_a];
  end

  assign in_tready  = (state_r == ST_LOAD);
  assign out_tvalid = ov_r;
  assign out_tdata  = {5'd0, ob_r.tag, ob_r.key};
  assign out_tlast  = ol_r;
  assign out_tuser  = od_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    pos_nxt = pos_r;
    ovf_nxt = ovf_r;
    last_nxt = last_r;
    new_nxt = new_r;
    emit_pend_nxt = emit_pend_r;
    epos_nxt = epos_r;
    ov_nxt = ov_r;
    ob_nxt = ob_r;
    ol_nxt = ol_r;
    od_nxt = od_r;
    rd_en = 1'b0;
    wr_en = 1'b0;
    rd_a = '0;
    wr_a = '0;
    wr_d = new_r;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        if (in_tvalid) begin
          new_nxt.key = in_tdata[KEY_W-1:0];
          new_nxt.tag = in_tdata[KEY_W+TAG_W-1:KEY_W];
          last_nxt = in_tlast;
          if (cnt_r == FULL) begin
            ovf_nxt = 1'b1;
            state_nxt = in_tlast ? ST_EMIT : ST_LOAD;
            epos_nxt = '0;
            emit_pend_nxt = 1'b0;
          end else if (cnt_r == '0) begin
            wr_en = 1'b1;
            wr_a = '0;
            wr_d.key = in_tdata[KEY_W-1:0];
            wr_d.tag = in_tdata[KEY_W+TAG_W-1:KEY_W];
            cnt_nxt = cnt_r + 1'b1;
            state_nxt = in_tlast ? ST_EMIT : ST_LOAD;
            epos_nxt = '0;
            emit_pend_nxt = 1'b0;
          end else begin
            rd_en = 1'b1;
            rd_a = AW'(cnt_r - 1'b1);
            pos_nxt = cnt_r;
            state_nxt = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        // rd_q holds entry pos_r-1
        if (rd_q.key > new_r.key) begin
          wr_en = 1'b1;
          wr_a = AW'(pos_r);
          wr_d = rd_q;
          pos_nxt = pos_r - 1'b1;
          if (pos_r == CW'(1)) begin
            state_nxt = ST_WAIT;
          end else begin
            rd_en = 1'b1;
            rd_a = AW'(pos_r - CW'(2));
          end
        end else begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        wr_en = 1'b1;
        wr_a = AW'(pos_r);
        wr_d = new_r;
        cnt_nxt = cnt_r + 1'b1;
        state_nxt = last_r ? ST_EMIT : ST_LOAD;
        epos_nxt = '0;
        emit_pend_nxt = 1'b0;
      end
      ST_EMIT: begin
        if (emit_pend_r && (!ov_r || out_tready)) begin
          ov_nxt = 1'b1;
          ob_nxt = rd_q;
          ol_nxt = (epos_r == cnt_r);
          od_nxt = ovf_r;
          emit_pend_nxt = 1'b0;
          if (epos_r == cnt_r) begin
            state_nxt = ST_LOAD;
            cnt_nxt = '0;
            ovf_nxt = 1'b0;
          end
        end
        if ((!emit_pend_r || (!ov_r || out_tready)) && epos_r != cnt_r) begin
          rd_en = 1'b1;
          rd_a = AW'(epos_r);
          epos_nxt = epos_r + 1'b1;
          emit_pend_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r <= '0;
      ovf_r <= 1'b0;
      ov_r <= 1'b0;
      emit_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
      ov_r <= ov_nxt;
      emit_pend_r <= emit_pend_nxt;
    end
    pos_r <= pos_nxt;
    last_r <= last_nxt;
    new_r <= new_nxt;
    epos_r <= epos_nxt;
    ob_r <= ob_nxt;
    ol_r <= ol_nxt;
    od_r <= od_nxt;
  end
endmodule
`default_nettype wire

@@ hdl/rsk_checker.sv @@
`default_nettype none
`include "record_sort_by_key_unit_macros.svh"
module rsk_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic        out_tuser
);
  `RSK_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled beat changed")
  `RSK_ASSERT_IMPL(a_fill, clk, rst_n, out_tvalid, out_tdata[63:59] == 5'd0, "fill bits set")
  `RSK_ASSERT_NEXT(a_flag, clk, rst_n, out_tvalid && out_tready && !out_tlast, !out_tvalid || out_tuser == $past(out_tuser), "dropped flag changed in run")
  `RSK_ASSERT_IMPL(a_noin, clk, rst_n, out_tvalid && !out_tlast, !in_tready || !in_tvalid || !in_tvalid, "input during run")
endmodule
bind record_sort_by_key_unit rsk_checker u_chk (.*);
`default_nettype wire

@@ dv/record_sort_by_key_unit_tb.sv @@
`timescale 1ns / 1ps
module record_sort_by_key_unit_tb import rsk_pkg::*;;

  localparam int unsigned ENTRIES = 64;
  localparam int unsigned DIR_ROWS = 12;

  typedef struct packed {
    key_t key;
    tag_t tag;
    logic last;
    logic dropped;
  } sorted_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic out_tlast;
  logic out_tuser;

  record_sort_by_key_unit #(.ENTRIES(ENTRIES)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  rec_t list_store[$];
  logic list_overflow = 1'b0;
  sorted_beat_t sorted_q[$];
  int mismatches = 0;
  bit stim_done = 1'b0;
  int stall_n = 0;

  function automatic void sort_insert(key_t k, tag_t t, logic lst);
    int pos;
    rec_t r;
    sorted_beat_t b;
    r.key = k;
    r.tag = t;
    if (list_store.size() >= ENTRIES) begin
      list_overflow = 1'b1;
    end else begin
      pos = list_store.size();
      while (pos > 0 && list_store[pos-1].key > k) pos--;
      list_store.insert(pos, r);
    end
    if (lst) begin
      foreach (list_store[i]) begin
        b.key = list_store[i].key;
        b.tag = list_store[i].tag;
        b.last = (i == list_store.size() - 1);
        b.dropped = list_overflow;
        sorted_q.push_back(b);
      end
      list_store.delete();
      list_overflow = 1'b0;
    end
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? int'($urandom_range(5, 30)) :
                                         int'($urandom_range(0, 2));
  endfunction

  task automatic send_record(key_t k, tag_t t, logic lst, bit idle);
    int n;
    n = idle ? gap_len() : 0;
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, t, k};
    in_tlast <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sort_insert(k, t, lst);
  endtask

  // directed rows
  key_t dir_key[DIR_ROWS] = '{27'h7FFFFFF, 27'd0, 27'd99999999, 27'd5, 27'd5, 27'd0,
                              27'd42, 27'd7, 27'd7, 27'd3, 27'h7FFFFFF, 27'd1};
  tag_t dir_tag[DIR_ROWS] = '{32'hFFFFFFFF, 32'h0, 32'hA5A5A5A5, 32'h1, 32'h2, 32'h3,
                              32'h5A5A5A5A, 32'h10, 32'h11, 32'h12, 32'h0, 32'hFFFFFFFF};
  logic dir_last[DIR_ROWS] = '{0, 0, 0, 0, 0, 1, 1, 0, 0, 1, 0, 1};

  initial begin
    int burst;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < DIR_ROWS; i++) send_record(dir_key[i], dir_tag[i], dir_last[i], 1);
    // overflow: ENTRIES + 3 records, last one dropped too
    for (int i = 0; i < ENTRIES + 3; i++)
      send_record(KEY_W'($urandom()), $urandom(), i == ENTRIES + 2, 0);
    // exactly full
    for (int i = 0; i < ENTRIES; i++)
      send_record(KEY_W'($urandom_range(0, 15)), $urandom(), i == ENTRIES - 1,
                  ($urandom_range(0, 3) == 0));
    // random lists, mostly short, narrow keys often to force ties
    for (int items = 0; items < 30; items += burst) begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      for (int j = 0; j < burst; j++)
        send_record(KEY_W'($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom()),
                    $urandom(), j == burst - 1, $urandom_range(0, 2) == 0);
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // result side
  always @(posedge clk) begin
    sorted_beat_t exp_b;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (sorted_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat key=%0d tag=%h", out_tdata[26:0],
                                         out_tdata[58:27]);
        end else begin
          exp_b = sorted_q.pop_front();
          if (out_tdata[26:0] !== exp_b.key || out_tdata[58:27] !== exp_b.tag ||
              out_tdata[63:59] !== 5'b0 || out_tlast !== exp_b.last ||
              out_tuser !== exp_b.dropped) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp key=%0d tag=%h last=%b drop=%b got key=%0d tag=%h last=%b drop=%b",
                       exp_b.key, exp_b.tag, exp_b.last, exp_b.dropped, out_tdata[26:0],
                       out_tdata[58:27], out_tlast, out_tuser);
          end
        end
      end
      if (stall_n > 0) begin
        stall_n--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 49) == 0) begin
        stall_n = $urandom_range(5, 30);
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 19) == 0) ? 1'b0 :
                      (($urandom_range(0, 3) == 0) ? 1'($urandom_range(0, 1)) : 1'b1);
      end
    end
  end

  initial begin
    wait (stim_done);
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && sorted_q.size() == 0) begin
      $display("PASS record_sort_by_key_unit");
    end else begin
      $display("FAIL record_sort_by_key_unit");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL record_sort_by_key_unit");
    $finish;
  end
endmodule
